// ===== hw/rtl/slrc_pkg.sv =====
// Shared types and constants of the set-associative write-back cache controller.
// No dependencies; imported by every module of the block.
`default_nettype none
package slrc_pkg;

    // Width of the block addresses on the result channel.
    localparam int BLOCK_W = 27;

    // Access kinds.
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_READ  = 3'b010,
        ST_LOOK  = 3'b100
    } back_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/set_assoc_lru_writeback_cache.sv =====
// Set-associative LRU write-back, write-allocate cache tag controller (top level).
// Instantiates slrc_front and slrc_back; uses slrc_pkg.
//
// Each accepted access yields exactly one result: hit, or a miss with a fetch of
// the missing block and, when a dirty line is evicted, a writeback of the victim.
// An access passes through the back-end states ST_READ, which reads its set from the
// set memory, and ST_LOOK, which compares, updates and writes the set back and holds
// while a result waits unread; the back end takes no new access until the last is
// through. A two-entry queue ahead of the back end and a result register let inputs
// keep flowing while a result waits. After reset the block clears its set memory,
// one set per cycle, and accepts no access into the back end until that pass is done.
`default_nettype none
module set_assoc_lru_writeback_cache #(
    parameter int WAYS              = 4,
    parameter int SET_INDEX_BITS    = 6,
    parameter int BLOCK_OFFSET_BITS = 5,
    parameter int ADDRESS_BITS      = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_action,
    input  wire logic [31:0]                s_address,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_hit,
    output logic                            m_writeback_valid,
    output logic [slrc_pkg::BLOCK_W-1:0]    m_writeback_block,
    output logic                            m_fetch_valid,
    output logic [slrc_pkg::BLOCK_W-1:0]    m_fetch_block
);
    import slrc_pkg::*;

    localparam int SET_W = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1;
    localparam int BLK_W = ADDRESS_BITS - BLOCK_OFFSET_BITS;
    localparam int TAG_W = BLK_W - SET_INDEX_BITS;

    logic               q_valid, q_ready, q_write;
    logic [SET_W-1:0]   q_set;
    logic [TAG_W-1:0]   q_tag;
    logic [BLK_W-1:0]   q_block;

    slrc_front #(
        .SET_W(SET_W), .SET_INDEX_BITS(SET_INDEX_BITS), .TAG_W(TAG_W), .BLK_W(BLK_W),
        .BLOCK_OFFSET_BITS(BLOCK_OFFSET_BITS), .ADDRESS_BITS(ADDRESS_BITS)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action), .s_address(s_address),
        .q_valid(q_valid), .q_ready(q_ready), .q_write(q_write),
        .q_set(q_set), .q_tag(q_tag), .q_block(q_block)
    );

    slrc_back #(
        .WAYS(WAYS), .SET_W(SET_W), .SET_INDEX_BITS(SET_INDEX_BITS),
        .TAG_W(TAG_W), .BLK_W(BLK_W)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_write(q_write),
        .q_set(q_set), .q_tag(q_tag), .q_block(q_block),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
        .m_writeback_valid(m_writeback_valid), .m_writeback_block(m_writeback_block),
        .m_fetch_valid(m_fetch_valid), .m_fetch_block(m_fetch_block)
    );

    // A result is either a hit or a miss that fetches.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hit != m_fetch_valid))
        else $error("hit and fetch disagree");

    // A writeback only happens as part of a miss.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_writeback_valid |-> m_fetch_valid)
        else $error("writeback without fetch");

    // Block addresses read as zero when their flag is low.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_fetch_valid || m_fetch_block == '0)
                     && (m_writeback_valid || m_writeback_block == '0)))
        else $error("block address set without its flag");

endmodule
`default_nettype wire

// ===== hw/rtl/slrc_front.sv =====
// Front end: accepts accesses, splits the address into set, tag and block,
// and holds them in a two-entry queue for the back end. Uses slrc_pkg.
`default_nettype none
module slrc_front #(
    parameter int SET_W  = 6,
    parameter int SET_INDEX_BITS = 6,
    parameter int TAG_W  = 21,
    parameter int BLK_W  = 27,
    parameter int BLOCK_OFFSET_BITS = 5,
    parameter int ADDRESS_BITS = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_action,
    input  wire logic [31:0]       s_address,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output logic                   q_write,
    output logic [SET_W-1:0]       q_set,
    output logic [TAG_W-1:0]       q_tag,
    output logic [BLK_W-1:0]       q_block
);
    import slrc_pkg::*;

    logic                   wr_ptr_reg, rd_ptr_reg;
    logic [1:0]             cnt_reg;
    logic [1:0]             ent_write_reg;
    logic [1:0][SET_W-1:0]  ent_set_reg;
    logic [1:0][TAG_W-1:0]  ent_tag_reg;
    logic [1:0][BLK_W-1:0]  ent_block_reg;
    logic [BLK_W-1:0]       block;
    logic                   push, pop;

    assign block   = s_address[ADDRESS_BITS-1:BLOCK_OFFSET_BITS];
    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    assign q_write = ent_write_reg[rd_ptr_reg];
    assign q_set   = ent_set_reg[rd_ptr_reg];
    assign q_tag   = ent_tag_reg[rd_ptr_reg];
    assign q_block = ent_block_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop) cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push) cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_write_reg[wr_ptr_reg] <= (s_action == ACT_WRITE);
            ent_set_reg[wr_ptr_reg]   <= (SET_INDEX_BITS > 0) ? SET_W'(block) : '0;
            ent_tag_reg[wr_ptr_reg]   <= TAG_W'(block >> SET_INDEX_BITS);
            ent_block_reg[wr_ptr_reg] <= block;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/slrc_back.sv =====
// Back end: set memories, tag compare, LRU update and replacement, and the
// result register. Uses slrc_pkg.
`default_nettype none
module slrc_back #(
    parameter int WAYS   = 4,
    parameter int SET_W  = 6,
    parameter int SET_INDEX_BITS = 6,
    parameter int TAG_W  = 21,
    parameter int BLK_W  = 27
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       q_valid,
    output logic                            q_ready,
    input  wire logic                       q_write,
    input  wire logic [SET_W-1:0]           q_set,
    input  wire logic [TAG_W-1:0]           q_tag,
    input  wire logic [BLK_W-1:0]           q_block,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_hit,
    output logic                            m_writeback_valid,
    output logic [slrc_pkg::BLOCK_W-1:0]    m_writeback_block,
    output logic                            m_fetch_valid,
    output logic [slrc_pkg::BLOCK_W-1:0]    m_fetch_block
);
    import slrc_pkg::*;

    localparam int NUM_SETS = 1 << SET_INDEX_BITS;
    localparam int AGE_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;
    typedef logic [WAYS-1:0][AGE_W-1:0] age_row_t;

    tag_row_t               mem_tag [NUM_SETS];
    logic [WAYS-1:0]        mem_vld [NUM_SETS];
    logic [WAYS-1:0]        mem_dty [NUM_SETS];
    age_row_t               mem_age [NUM_SETS];

    back_state_t            state_reg;
    logic [SET_W-1:0]       clr_reg;
    tag_row_t               rd_tag_reg;
    logic [WAYS-1:0]        rd_vld_reg, rd_dty_reg;
    age_row_t               rd_age_reg;
    logic                   cur_write_reg;
    logic [SET_W-1:0]       cur_set_reg;
    logic [TAG_W-1:0]       cur_tag_reg;
    logic [BLK_W-1:0]       cur_block_reg;

    logic                   out_valid_reg, out_hit_reg, out_wb_reg, out_fetch_reg;
    logic [BLOCK_W-1:0]     out_wb_blk_reg, out_fetch_blk_reg;

    logic                   advance, mem_we, any_hit, any_inv;
    logic [AGE_W-1:0]       slot, slot_hit, slot_inv, slot_vic, pivot;
    logic [SET_W-1:0]       wr_set;
    tag_row_t               new_tag;
    logic [WAYS-1:0]        new_vld, new_dty;
    age_row_t               new_age;
    logic [BLK_W-1:0]       victim;
    logic                   wb;

    assign q_ready = (state_reg == ST_READ);
    assign advance = (state_reg == ST_LOOK) && (!out_valid_reg || m_ready);

    always_comb begin
        any_hit  = 1'b0;
        any_inv  = 1'b0;
        slot_hit = '0;
        slot_inv = '0;
        slot_vic = '0;
        // Scan downward so the lowest-numbered matching way wins.
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (rd_vld_reg[w] && rd_tag_reg[w] == cur_tag_reg) begin
                any_hit  = 1'b1;
                slot_hit = AGE_W'(w);
            end
            if (!rd_vld_reg[w]) begin
                any_inv  = 1'b1;
                slot_inv = AGE_W'(w);
            end
        end
        // Ages are a permutation, so the oldest way holds age WAYS-1.
        for (int w = 0; w < WAYS; w++) begin
            if (rd_age_reg[w] == AGE_W'(WAYS - 1)) slot_vic = AGE_W'(w);
        end
        slot = any_hit ? slot_hit : (any_inv ? slot_inv : slot_vic);
        pivot = rd_age_reg[slot];
        new_tag = rd_tag_reg;
        new_vld = rd_vld_reg;
        new_dty = rd_dty_reg;
        new_age = rd_age_reg;
        if (any_hit) begin
            new_dty[slot] = rd_dty_reg[slot] | cur_write_reg;
        end else begin
            new_tag[slot] = cur_tag_reg;
            new_vld[slot] = 1'b1;
            new_dty[slot] = cur_write_reg;
        end
        for (int w = 0; w < WAYS; w++) begin
            if (rd_age_reg[w] < pivot) new_age[w] = rd_age_reg[w] + AGE_W'(1);
        end
        new_age[slot] = '0;
        victim = (BLK_W'(rd_tag_reg[slot_vic]) << SET_INDEX_BITS) | BLK_W'(cur_set_reg);
        wb = !any_hit && !any_inv && rd_dty_reg[slot_vic];

        // During the clearing pass each set gets invalid ways and fresh ages.
        mem_we = (state_reg == ST_CLEAR) || advance;
        wr_set = (state_reg == ST_CLEAR) ? clr_reg : cur_set_reg;
        if (state_reg == ST_CLEAR) begin
            new_tag = '0;
            new_vld = '0;
            new_dty = '0;
            for (int w = 0; w < WAYS; w++) new_age[w] = AGE_W'(w);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_tag[wr_set] <= new_tag;
            mem_vld[wr_set] <= new_vld;
            mem_dty[wr_set] <= new_dty;
            mem_age[wr_set] <= new_age;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            rd_tag_reg    <= mem_tag[q_set];
            rd_vld_reg    <= mem_vld[q_set];
            rd_dty_reg    <= mem_dty[q_set];
            rd_age_reg    <= mem_age[q_set];
            cur_write_reg <= q_write;
            cur_set_reg   <= q_set;
            cur_tag_reg   <= q_tag;
            cur_block_reg <= q_block;
        end
        if (advance) begin
            out_hit_reg       <= any_hit;
            out_wb_reg        <= wb;
            out_wb_blk_reg    <= wb ? BLOCK_W'(victim) : '0;
            out_fetch_reg     <= !any_hit;
            out_fetch_blk_reg <= any_hit ? '0 : BLOCK_W'(cur_block_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + SET_W'(1);
                    if (clr_reg == SET_W'(NUM_SETS - 1)) state_reg <= ST_READ;
                end
                ST_READ: begin
                    if (q_valid) state_reg <= ST_LOOK;
                end
                ST_LOOK: begin
                    if (advance) state_reg <= ST_READ;
                end
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_hit             = out_hit_reg;
    assign m_writeback_valid = out_wb_reg;
    assign m_writeback_block = out_wb_blk_reg;
    assign m_fetch_valid     = out_fetch_reg;
    assign m_fetch_block     = out_fetch_blk_reg;

endmodule
`default_nettype wire
